// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// explicit clock and active-low reset
`define QRS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// default clock and reset names
`define QRS_ASSERT(lbl, prop, msg) `QRS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`endif

// ===== design/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Default widths and root status codes.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int CoefWidthDef = 16;
  localparam int FracBitsDef  = 16;
  localparam int RootWidth    = 40;
  localparam int CountWidth   = 2;

  typedef logic [CountWidth-1:0] root_count_t;
  typedef logic [RootWidth-1:0]  root_t;

  localparam root_count_t CntNone    = 2'd0;
  localparam root_count_t CntDouble  = 2'd1;
  localparam root_count_t CntTwo     = 2'd2;
  localparam root_count_t CntNotQuad = 2'd3;

endpackage

// ===== design/qrs_req_if.sv =====
// ----------------------------------------------------------------------------
// Coefficient request channel
// Valid/ready channel carrying one set of coefficients a, b and c.
// ----------------------------------------------------------------------------
interface qrs_req_if import qrs_pkg::*; #(
  parameter int COEF_WIDTH = CoefWidthDef
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

// ===== design/qrs_res_if.sv =====
// ----------------------------------------------------------------------------
// Root result channel
// Valid/ready channel carrying the status and the two fixed-point roots.
// ----------------------------------------------------------------------------
interface qrs_res_if import qrs_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic [CountWidth-1:0]       root_count;
  logic signed [RootWidth-1:0] root_one;
  logic signed [RootWidth-1:0] root_two;

  modport source (output valid, output root_count, output root_one, output root_two,
                  input ready);
  modport sink   (input valid, input root_count, input root_one, input root_two,
                  output ready);
endinterface

// ===== design/quadratic_root_solver_top.sv =====
// Throughput: one request per cycle while the result is not stalled; set by the
// bit-per-stage square root and dividers.
// A stalled result holds the whole pipeline; bubbles travel with cleared valid bits.
// Reset clears all valid bits at once; no clearing pass, no state kept between requests.
// ----------------------------------------------------------------------------
// Quadratic root solver
// Discriminant, bit-per-stage square root and two bit-per-stage dividers.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top import qrs_pkg::*; #(
  parameter int COEF_WIDTH = CoefWidthDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  qrs_req_if.sink   req_i,
  qrs_res_if.source res_o
);

  localparam int W    = COEF_WIDTH;
  localparam int DW   = 2 * W + 1;           // discriminant
  localparam int SW   = W + FRAC_BITS + 1;   // square root bits
  localparam int RDW  = 2 * SW;              // scaled radicand
  localparam int REMW = SW + 2;              // root remainder
  localparam int NUMW = W + FRAC_BITS + 1;   // -b scaled
  localparam int NW   = W + FRAC_BITS + 2;   // numerator magnitude / quotient
  localparam int DENW = W + 1;               // 2|a|
  localparam int MXW  = (NW > RootWidth + 1) ? NW : RootWidth + 1;
  localparam logic [MXW-1:0] PosLim = MXW'((64'd1 << (RootWidth - 1)) - 64'd1);
  localparam logic [MXW-1:0] NegLim = MXW'(64'd1 << (RootWidth - 1));

  typedef struct packed {
    root_count_t             cnt;
    logic signed [NUMW-1:0]  num;
    logic [DENW-1:0]         den;
    logic                    dneg;
  } sq_ctl_t;

  typedef struct packed {
    logic [NW-1:0]   dd1;
    logic [NW-1:0]   dd2;
    logic [DENW-1:0] r1;
    logic [DENW-1:0] r2;
    logic            neg1;
    logic            neg2;
    root_count_t     cnt;
    logic [DENW-1:0] den;
  } dv_t;

  function automatic root_t sat_root(input logic [NW-1:0] q, input logic neg);
    logic [MXW-1:0] mx;
    root_t          t;
    mx = MXW'(q);
    t  = mx[RootWidth-1:0];
    if (!neg && mx > PosLim) begin
      sat_root = PosLim[RootWidth-1:0];
    end else if (neg && mx > NegLim) begin
      sat_root = NegLim[RootWidth-1:0];
    end else begin
      sat_root = neg ? -t : t;
    end
  endfunction

  logic en;
  logic out_vld_q;

  assign en          = !out_vld_q || res_o.ready;
  assign req_i.ready = en;

  // stage 1: magnitudes and signs
  logic                v1_q;
  logic [W-1:0]        ma1_q, mb1_q, mc1_q;
  logic                sa1_q, sc1_q, az1_q;
  logic signed [W-1:0] b1_q;

  // stage 2: products
  logic                v2_q;
  logic [2*W-1:0]      b2_q, ac2_q;
  logic [W-1:0]        ma2_q;
  logic                sa2_q, sgn2_q, az2_q;
  logic signed [W-1:0] b2c_q;

  // square root pipe, index 0 loaded by the discriminant stage
  logic            sv_q   [SW+1];
  logic [RDW-1:0]  rad_q  [SW+1];
  logic [REMW-1:0] rem_q  [SW+1];
  logic [SW-1:0]   root_q [SW+1];
  sq_ctl_t         sc_q   [SW+1];

  // divider pipe
  logic dvv_q [NW+1];
  dv_t  dv_q  [NW+1];

  root_count_t out_cnt_q;
  root_t       out_one_q, out_two_q;

  // stage 3 combinational
  logic [2*W+1:0]        b2x, ac4, dsum;
  logic                  ac_pos, dneg_d;
  logic [DW-1:0]         delta;
  root_count_t           cnt_d;
  logic signed [NUMW-1:0] num_d;

  always_comb begin
    b2x    = (2*W+2)'(b2_q);
    ac4    = {ac2_q, 2'b00};
    ac_pos = (ac2_q != '0) && !sgn2_q;
    dneg_d = ac_pos && (b2x < ac4);
    dsum   = ac_pos ? (b2x - ac4) : (b2x + ac4);
    delta  = dsum[DW-1:0];
    if (az2_q) begin
      cnt_d = CntNotQuad;
    end else if (dneg_d) begin
      cnt_d = CntNone;
    end else if (delta == '0) begin
      cnt_d = CntDouble;
    end else begin
      cnt_d = CntTwo;
    end
    num_d = (-NUMW'(b2c_q)) <<< FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      sv_q[0]  <= 1'b0;
    end else if (en) begin
      v1_q     <= req_i.valid;
      v2_q     <= v1_q;
      sv_q[0]  <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma1_q <= req_i.coef_a[W-1] ? (~req_i.coef_a + 1'b1) : req_i.coef_a;
      mb1_q <= req_i.coef_b[W-1] ? (~req_i.coef_b + 1'b1) : req_i.coef_b;
      mc1_q <= req_i.coef_c[W-1] ? (~req_i.coef_c + 1'b1) : req_i.coef_c;
      sa1_q <= req_i.coef_a[W-1];
      sc1_q <= req_i.coef_c[W-1];
      az1_q <= (req_i.coef_a == '0);
      b1_q  <= req_i.coef_b;

      b2_q   <= (2*W)'(mb1_q) * (2*W)'(mb1_q);
      ac2_q  <= (2*W)'(ma1_q) * (2*W)'(mc1_q);
      ma2_q  <= ma1_q;
      sa2_q  <= sa1_q;
      sgn2_q <= sa1_q ^ sc1_q;
      az2_q  <= az1_q;
      b2c_q  <= b1_q;

      rad_q[0]    <= RDW'(delta) << (2 * FRAC_BITS);
      rem_q[0]    <= '0;
      root_q[0]   <= '0;
      sc_q[0].cnt  <= cnt_d;
      sc_q[0].num  <= num_d;
      sc_q[0].den  <= {ma2_q, 1'b0};
      sc_q[0].dneg <= sa2_q;
    end
  end

  // one root bit per stage, restoring
  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [REMW-1:0] rem_sh, trial;
    logic            ge;

    always_comb begin
      rem_sh = {rem_q[k][REMW-3:0], rad_q[k][RDW-1:RDW-2]};
      trial  = {root_q[k], 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (en) begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rad_q[k+1]  <= rad_q[k] << 2;
        rem_q[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k+1] <= {root_q[k][SW-2:0], ge};
        sc_q[k+1]   <= sc_q[k];
      end
    end
  end

  // numerators -b*2^F +/- sqrt, split into magnitude and quotient sign
  logic signed [NW:0] n1, n2;

  always_comb begin
    n1 = (NW+1)'(sc_q[SW].num) + (NW+1)'($signed({1'b0, root_q[SW]}));
    n2 = (NW+1)'(sc_q[SW].num) - (NW+1)'($signed({1'b0, root_q[SW]}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else if (en) begin
      dvv_q[0] <= sv_q[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0].dd1  <= n1[NW] ? NW'(-n1) : NW'(n1);
      dv_q[0].dd2  <= n2[NW] ? NW'(-n2) : NW'(n2);
      dv_q[0].r1   <= '0;
      dv_q[0].r2   <= '0;
      dv_q[0].neg1 <= n1[NW] ^ sc_q[SW].dneg;
      dv_q[0].neg2 <= n2[NW] ^ sc_q[SW].dneg;
      dv_q[0].cnt  <= sc_q[SW].cnt;
      dv_q[0].den  <= sc_q[SW].den;
    end
  end

  // one quotient bit per stage for both roots; quotient shifts into dd
  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DENW:0] rx1, rx2, dx;
    logic          ge1, ge2;
    dv_t           nx;

    always_comb begin
      dx      = {1'b0, dv_q[k].den};
      rx1     = {dv_q[k].r1, dv_q[k].dd1[NW-1]};
      rx2     = {dv_q[k].r2, dv_q[k].dd2[NW-1]};
      ge1     = rx1 >= dx;
      ge2     = rx2 >= dx;
      nx      = dv_q[k];
      nx.r1   = ge1 ? DENW'(rx1 - dx) : DENW'(rx1);
      nx.r2   = ge2 ? DENW'(rx2 - dx) : DENW'(rx2);
      nx.dd1  = {dv_q[k].dd1[NW-2:0], ge1};
      nx.dd2  = {dv_q[k].dd2[NW-2:0], ge2};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[k+1] <= 1'b0;
      end else if (en) begin
        dvv_q[k+1] <= dvv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k+1] <= nx;
      end
    end
  end

  // output register: sign, saturate, blank unused roots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dvv_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_cnt_q <= dv_q[NW].cnt;
      out_one_q <= (dv_q[NW].cnt == CntTwo || dv_q[NW].cnt == CntDouble) ?
                   sat_root(dv_q[NW].dd1, dv_q[NW].neg1) : '0;
      out_two_q <= (dv_q[NW].cnt == CntTwo) ? sat_root(dv_q[NW].dd2, dv_q[NW].neg2) : '0;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.root_count = out_cnt_q;
  assign res_o.root_one   = out_one_q;
  assign res_o.root_two   = out_two_q;

endmodule

// ===== design/qrs_checker.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qrs_checker import qrs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input root_count_t root_count_i,
  input root_t       root_one_i,
  input root_t       root_two_i
);

  logic [7:0] inflight_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  `QRS_ASSERT(a_res_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `QRS_ASSERT(a_res_stable, out_valid_i && !out_ready_i |=> $stable(root_count_i) && $stable(root_one_i) && $stable(root_two_i), "stalled result changed")
  `QRS_ASSERT(a_res_origin, out_valid_i |-> inflight_q != 8'd0, "result without a request")
  `QRS_ASSERT(a_res_blank, out_valid_i && (root_count_i == CntNone || root_count_i == CntNotQuad) |-> root_one_i == '0 && root_two_i == '0, "roots not zero without real roots")
  `QRS_ASSERT(a_res_double, out_valid_i && root_count_i == CntDouble |-> root_two_i == '0, "second root set for a double root")

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .root_count_i (res_o.root_count),
  .root_one_i   (res_o.root_one),
  .root_two_i   (res_o.root_two)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Sends coefficient requests with random gaps and checks each status and
// fixed-point root pair against a predictor built on wide exact arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import qrs_pkg::*;

  localparam int CW = CoefWidthDef;
  localparam int FB = FracBitsDef;

  typedef struct {
    root_count_t cnt;
    root_t       one;
    root_t       two;
  } roots_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qrs_req_if #(.COEF_WIDTH(CW)) req_if ();
  qrs_res_if res_if ();

  quadratic_root_solver_top #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  roots_t roots_q[$];
  int     n_err = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // floor square root of a value below 2^128
  function automatic logic [127:0] isqrt(input logic [127:0] v);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic root_t sat_root(input logic signed [127:0] num,
                                     input logic signed [127:0] den);
    logic signed [127:0] q;
    logic signed [127:0] hi;
    hi = (128'sd1 <<< (RootWidth - 1)) - 1;
    q = num / den; // truncates toward zero
    if (q > hi) q = hi;
    if (q < -hi - 1) q = -hi - 1;
    return q[RootWidth-1:0];
  endfunction

  function automatic roots_t solve_roots(input logic signed [CW-1:0] a,
                                         input logic signed [CW-1:0] b,
                                         input logic signed [CW-1:0] c);
    roots_t r;
    logic signed [127:0] wa, wb, wc, disc, num, s;
    r.cnt = CntNotQuad;
    r.one = '0;
    r.two = '0;
    wa = a;
    wb = b;
    wc = c;
    if (a == 0) return r;
    disc = wb * wb - 4 * wa * wc;
    num = -wb * (128'sd1 <<< FB);
    if (disc < 0) begin
      r.cnt = CntNone;
    end else if (disc == 0) begin
      r.cnt = CntDouble;
      r.one = sat_root(num, 2 * wa);
    end else begin
      r.cnt = CntTwo;
      s = isqrt(disc <<< (2 * FB));
      r.one = sat_root(num + s, 2 * wa);
      r.two = sat_root(num - s, 2 * wa);
    end
    return r;
  endfunction

  // valid stays high into the next request when no gap is drawn
  task automatic send_coefs(input logic [CW-1:0] a, input logic [CW-1:0] b,
                            input logic [CW-1:0] c);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.coef_a <= a;
    req_if.coef_b <= b;
    req_if.coef_c <= c;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    roots_q.push_back(solve_roots(a, b, c));
  endtask

  // result side: random stalls, compare against the oldest prediction
  initial begin
    roots_t e;
    int stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      if (roots_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result cnt=%0d", res_if.root_count);
      end else begin
        e = roots_q.pop_front();
        if (res_if.root_count !== e.cnt || res_if.root_one !== e.one ||
            res_if.root_two !== e.two) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch exp cnt=%0d one=%h two=%h got cnt=%0d one=%h two=%h",
                     e.cnt, e.one, e.two, res_if.root_count, res_if.root_one,
                     res_if.root_two);
        end
      end
    end
  end

  task automatic test_special_cases();
    send_coefs(16'sd0, 16'sd5, 16'sd3);        // not quadratic
    send_coefs(16'sd0, 16'sd0, 16'sd0);
    send_coefs(16'sd1, 16'sd0, 16'sd1);        // no real root
    send_coefs(16'sd1, -16'sd2, 16'sd1);       // double root
    send_coefs(-16'sd3, 16'sd6, -16'sd3);
    send_coefs(16'sd2, 16'sd7, -16'sd4);       // two roots
    send_coefs(-16'sd5, 16'sd1, 16'sd9);
    send_coefs(16'sd1, 16'sd0, 16'sd0);
    send_coefs(16'sd1, 16'sd1, 16'sd0);
  endtask

  task automatic test_extremes();
    logic [CW-1:0] ext[4];
    ext[0] = 16'h8000; ext[1] = 16'h7fff; ext[2] = 16'hffff; ext[3] = 16'h0001;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j += 2)
        send_coefs(ext[i], ext[(i + j + 1) % 4], ext[j]);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h0001, 16'h8000, 16'h7fff);
  endtask

  task automatic test_random(input int n);
    logic signed [CW-1:0] a, b, c, k, r1, r2;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: begin // double root: a*(x-r)^2, kept inside the coefficient range
          k = CW'($urandom_range(1, 7));
          r1 = CW'($signed(7'($urandom)));
          send_coefs(k, CW'(-2 * k * r1), CW'(k * r1 * r1));
        end
        1: begin // small coefficients
          a = CW'($signed(5'($urandom)));
          b = CW'($signed(5'($urandom)));
          c = CW'($signed(5'($urandom)));
          send_coefs(a, b, c);
        end
        2: begin // integer roots
          r1 = CW'($signed(7'($urandom)));
          r2 = CW'($signed(7'($urandom)));
          k = $urandom_range(0, 1) ? CW'(1) : CW'(-1);
          send_coefs(k, CW'(-k * (r1 + r2)), CW'(k * r1 * r2));
        end
        default: send_coefs(CW'($urandom), CW'($urandom), CW'($urandom));
      endcase
    end
  endtask

  initial begin
    req_if.valid  = 1'b0;
    req_if.coef_a = '0;
    req_if.coef_b = '0;
    req_if.coef_c = '0;
    repeat (5) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_extremes();
    test_random(1300);
    req_if.valid <= 1'b0;
    while (roots_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_err == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/qrs_pkg.sv
design/qrs_req_if.sv
design/qrs_res_if.sv
design/quadratic_root_solver_top.sv
design/qrs_checker.sv
test/tb.sv
